@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("implication check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

@@ src/pff_pkg.sv @@
`timescale 1ns / 1ps

package pff_pkg;

	// Frame limits
	localparam int MAX_ADDRESSES  = 10;
	localparam int MAX_INFO_BYTES = 256;
	localparam int ADDR_CNT_W     = $clog2(MAX_ADDRESSES + 1);
	localparam int INFO_CNT_W     = $clog2(MAX_INFO_BYTES + 1);

	// Minimum frame length in bytes, check sequence included
	localparam logic [3:0] MIN_FRAME_LEN = 4'd14;

	// CRC-16/X.25, reflected form
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_XOR  = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'h8408;

	// Callsign bytes in one address before the SSID byte
	localparam logic [2:0] CALL_LEN = 3'd6;

	// Control low bits that call for a PID byte
	localparam logic [1:0] CTRL_PID_CODE = 2'b11;

	typedef enum logic [2:0] {
		KIND_CALL = 3'd0,
		KIND_SSID = 3'd1,
		KIND_CTRL = 3'd2,
		KIND_PID  = 3'd3,
		KIND_INFO = 3'd4
	} field_kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_SHORT   = 2'd1,
		ST_NO_CTRL = 2'd2,
		ST_NO_PID  = 2'd3
	} status_t;

	// One result of the parser, with a flag for whether it exists
	typedef struct packed {
		logic        present;
		logic        byte_valid;
		logic [7:0]  field_byte;
		field_kind_t field_kind;
		logic [3:0]  address_slot;
		logic [7:0]  field_offset;
		logic        frame_done;
		status_t     status;
		logic [3:0]  address_total;
		logic [8:0]  info_total;
		logic        info_truncated;
		logic [15:0] received_check;
		logic        check_ok;
	} pff_result_t;

	// Fold one byte into the running CRC, LSB first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
		logic [15:0] c;
		c = crc ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (c[0]) begin
				c = (c >> 1) ^ CRC_POLY;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

@@ src/pff_if.sv @@
`timescale 1ns / 1ps

// Byte stream into the parser
interface pff_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       frame_end;

	modport source (output valid, output data_byte, output frame_end, input ready);
	modport sink (input valid, input data_byte, input frame_end, output ready);
endinterface

// Classified bytes and frame reports out of the parser
interface pff_out_if;
	logic        valid;
	logic        ready;
	logic        byte_valid;
	logic [7:0]  field_byte;
	logic [2:0]  field_kind;
	logic [3:0]  address_slot;
	logic [7:0]  field_offset;
	logic        frame_done;
	logic [1:0]  status;
	logic [3:0]  address_total;
	logic [8:0]  info_total;
	logic        info_truncated;
	logic [15:0] received_check;
	logic        check_ok;

	modport source (
		output valid, output byte_valid, output field_byte, output field_kind,
		output address_slot, output field_offset, output frame_done, output status,
		output address_total, output info_total, output info_truncated,
		output received_check, output check_ok, input ready
	);
	modport sink (
		input valid, input byte_valid, input field_byte, input field_kind,
		input address_slot, input field_offset, input frame_done, input status,
		input address_total, input info_total, input info_truncated,
		input received_check, input check_ok, output ready
	);
endinterface

@@ src/pff_core.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

// Frame state, byte classification and CRC for one byte per cycle while advance is high.
module pff_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 advance,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	output pff_pkg::pff_result_t result
);
	import pff_pkg::*;

	typedef enum logic [1:0] {
		PH_ADDR,
		PH_CTRL,
		PH_PID,
		PH_INFO
	} phase_t;

	typedef enum logic [1:0] {
		FILL_EMPTY,
		FILL_ONE,
		FILL_FULL
	} fill_t;

	logic [7:0]            dly0_q, dly1_q, dly0_d, dly1_d;
	fill_t                 fill_q, fill_d;
	phase_t                phase_q, phase_d;
	logic [2:0]            apos_q, apos_d;
	logic [ADDR_CNT_W-1:0] acnt_q, acnt_d, acnt_inc;
	logic [INFO_CNT_W-1:0] icnt_q, icnt_d;
	logic [3:0]            len_q, len_d;
	logic [15:0]           crc_q, crc_d;
	logic                  trunc_q, trunc_d;
	logic [15:0]           check;
	logic                  check_en;
	logic                  have;

	// Next state and result for the byte now in the input stage
	always_comb begin
		dly0_d   = dly0_q;
		dly1_d   = dly1_q;
		fill_d   = fill_q;
		phase_d  = phase_q;
		apos_d   = apos_q;
		acnt_d   = acnt_q;
		icnt_d   = icnt_q;
		trunc_d  = trunc_q;
		crc_d    = crc_q;
		len_d    = (len_q < MIN_FRAME_LEN) ? len_q + 4'd1 : len_q;
		acnt_inc = acnt_q + 1'b1;
		have     = 1'b0;
		check    = '0;
		check_en = 1'b0;
		result   = '0;

		case (fill_q)
			FILL_EMPTY: begin
				dly0_d = data_byte;
				fill_d = FILL_ONE;
				check  = {8'h00, data_byte};
			end
			FILL_ONE: begin
				dly1_d   = data_byte;
				fill_d   = FILL_FULL;
				check    = {data_byte, dly0_q};
				check_en = 1'b1;
			end
			default: begin
				// Release the oldest held byte into the body
				crc_d = crc_byte(crc_q, dly0_q);
				result.field_byte = dly0_q;
				case (phase_q)
					PH_ADDR: begin
						have = 1'b1;
						result.address_slot = 4'(acnt_q);
						if (apos_q < CALL_LEN) begin
							result.field_kind   = KIND_CALL;
							result.field_offset = 8'(apos_q);
							apos_d = apos_q + 3'd1;
						end else begin
							result.field_kind = KIND_SSID;
							apos_d = '0;
							acnt_d = acnt_inc;
							if (dly0_q[0] || (32'(acnt_inc) >= MAX_ADDRESSES)) begin
								phase_d = PH_CTRL;
							end
						end
					end
					PH_CTRL: begin
						have = 1'b1;
						result.field_kind = KIND_CTRL;
						phase_d = (dly0_q[1:0] == CTRL_PID_CODE) ? PH_PID : PH_INFO;
					end
					PH_PID: begin
						have = 1'b1;
						result.field_kind = KIND_PID;
						phase_d = PH_INFO;
					end
					default: begin
						if (32'(icnt_q) < MAX_INFO_BYTES) begin
							have = 1'b1;
							result.field_kind   = KIND_INFO;
							result.field_offset = 8'(icnt_q);
							icnt_d = icnt_q + 1'b1;
						end else begin
							trunc_d = 1'b1;
						end
					end
				endcase
				dly0_d   = dly1_q;
				dly1_d   = data_byte;
				check    = {data_byte, dly1_q};
				check_en = 1'b1;
			end
		endcase

		// Clear byte fields when nothing was classified
		if (!have) begin
			result.field_byte   = '0;
			result.field_kind   = KIND_CALL;
			result.address_slot = '0;
			result.field_offset = '0;
		end
		result.byte_valid = have;
		result.present    = have || frame_end;

		// Frame report
		if (frame_end) begin
			result.frame_done = 1'b1;
			if (len_d < MIN_FRAME_LEN) begin
				result.status = ST_SHORT;
			end else if (phase_d == PH_ADDR || phase_d == PH_CTRL) begin
				result.status = ST_NO_CTRL;
			end else if (phase_d == PH_PID) begin
				result.status = ST_NO_PID;
			end else begin
				result.status = ST_OK;
			end
			result.address_total  = 4'(acnt_d);
			result.info_total     = 9'(icnt_d);
			result.info_truncated = trunc_d;
			result.received_check = check;
			result.check_ok       = check_en && ((crc_d ^ CRC_XOR) == check);
		end
	end

	// Hold frame state; return to idle after every frame end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dly0_q  <= '0;
			dly1_q  <= '0;
			fill_q  <= FILL_EMPTY;
			phase_q <= PH_ADDR;
			apos_q  <= '0;
			acnt_q  <= '0;
			icnt_q  <= '0;
			len_q   <= '0;
			crc_q   <= CRC_INIT;
			trunc_q <= 1'b0;
		end else if (advance) begin
			if (frame_end) begin
				dly0_q  <= '0;
				dly1_q  <= '0;
				fill_q  <= FILL_EMPTY;
				phase_q <= PH_ADDR;
				apos_q  <= '0;
				acnt_q  <= '0;
				icnt_q  <= '0;
				len_q   <= '0;
				crc_q   <= CRC_INIT;
				trunc_q <= 1'b0;
			end else begin
				dly0_q  <= dly0_d;
				dly1_q  <= dly1_d;
				fill_q  <= fill_d;
				phase_q <= phase_d;
				apos_q  <= apos_d;
				acnt_q  <= acnt_d;
				icnt_q  <= icnt_d;
				len_q   <= len_d;
				crc_q   <= crc_d;
				trunc_q <= trunc_d;
			end
		end
	end

	`ASSERT_IMPLY(a_info_idle_in_header, clk, arst_n, phase_q != PH_INFO, icnt_q == '0 && !trunc_q)
	`ASSERT_IMPLY(a_body_needs_full_delay, clk, arst_n, phase_q != PH_ADDR || apos_q != '0, fill_q == FILL_FULL)
	`ASSERT_IMPLY(a_call_pos_bound, clk, arst_n, 1'b1, apos_q <= CALL_LEN)

endmodule

@@ src/packet_frame_field_parser_top.sv @@
`timescale 1ns / 1ps

`include "assert_macros.svh"

// The result a byte causes is computed from the input stage and registered when that stage advances.
// Throughput: one byte per cycle while results drain; a waiting result stalls the input stage.
// The trailing two check bytes give no classified result; the last byte carries the report.
// Reset (arst_n low, asynchronous) empties both stages and returns the frame state to idle;
// frame state also returns to idle after every frame end.
module packet_frame_field_parser_top (
	input logic clk,
	input logic arst_n,
	pff_in_if.sink    frame_in,
	pff_out_if.source field_out
);
	import pff_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        end_s1;
	logic        out_valid_q;
	pff_result_t res_q;
	pff_result_t res_d;
	logic        advance;

	// Move the input stage on when the result register is free or being drained
	assign advance        = valid_s1 && (!out_valid_q || field_out.ready);
	assign frame_in.ready = !valid_s1 || advance;

	// Input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (frame_in.ready) begin
			valid_s1 <= frame_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (frame_in.ready && frame_in.valid) begin
			byte_s1 <= frame_in.data_byte;
			end_s1  <= frame_in.frame_end;
		end
	end

	pff_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.data_byte (byte_s1),
		.frame_end (end_s1),
		.result    (res_d)
	);

	// Result register: load on a result, drop the transaction once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res_d.present) begin
			out_valid_q <= 1'b1;
		end else if (field_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_d.present) begin
			res_q <= res_d;
		end
	end

	assign field_out.valid          = out_valid_q;
	assign field_out.byte_valid     = res_q.byte_valid;
	assign field_out.field_byte     = res_q.field_byte;
	assign field_out.field_kind     = res_q.field_kind;
	assign field_out.address_slot   = res_q.address_slot;
	assign field_out.field_offset   = res_q.field_offset;
	assign field_out.frame_done     = res_q.frame_done;
	assign field_out.status         = res_q.status;
	assign field_out.address_total  = res_q.address_total;
	assign field_out.info_total     = res_q.info_total;
	assign field_out.info_truncated = res_q.info_truncated;
	assign field_out.received_check = res_q.received_check;
	assign field_out.check_ok       = res_q.check_ok;

	`ASSERT_IMPLY(a_slot_in_range, clk, arst_n, out_valid_q && res_q.byte_valid && (res_q.field_kind == KIND_CALL || res_q.field_kind == KIND_SSID), 32'(res_q.address_slot) < MAX_ADDRESSES)
	`ASSERT_IMPLY(a_ok_has_address, clk, arst_n, out_valid_q && res_q.frame_done && res_q.status == ST_OK, res_q.address_total != '0)
	`ASSERT_NEXT(a_result_holds, clk, arst_n, out_valid_q && !field_out.ready, out_valid_q && $stable(res_q))

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import pff_pkg::*;

	localparam int BYTE_GOAL = 1250;
	localparam int LONG_HOLD = 300;
	localparam int DRAIN_CYCLES = 10;

	typedef enum logic [1:0] {
		PH_ADDRESS,
		PH_CONTROL,
		PH_PID,
		PH_INFO
	} parse_phase_t;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_MOSTLY,
		RX_SPARSE
	} rx_mode_t;

	// Predicts parser reports per byte and matches them against the output stream
	class field_report_board;
		localparam int REPORT_LIMIT = 10;

		pff_result_t  awaited_reports[$];
		int           mismatches;
		logic [7:0]   held[2];
		int unsigned  fill;
		parse_phase_t phase;
		int unsigned  addr_pos;
		int unsigned  addr_count;
		int unsigned  info_count;
		int unsigned  length_seen;
		logic [15:0]  crc;
		logic         truncated;

		function new();
			mismatches = 0;
			clear_frame();
		endfunction

		// CRC-16/X.25, reflected, one data bit at a time
		static function logic [15:0] x25_update(logic [15:0] acc_in, logic [7:0] data);
			logic [15:0] acc;
			logic        fb;
			acc = acc_in;
			for (int i = 0; i < 8; i++) begin
				fb = acc[0] ^ data[i];
				acc = {1'b0, acc[15:1]};
				if (fb) begin
					acc = acc ^ CRC_POLY;
				end
			end
			return acc;
		endfunction

		function void clear_frame();
			held[0] = 8'h00;
			held[1] = 8'h00;
			fill = 0;
			phase = PH_ADDRESS;
			addr_pos = 0;
			addr_count = 0;
			info_count = 0;
			length_seen = 0;
			crc = CRC_INIT;
			truncated = 1'b0;
		endfunction

		// Advance the frame state by one accepted byte; queue the report it causes
		function void predict_byte(logic [7:0] b, logic last);
			pff_result_t  r;
			logic         have;
			logic [7:0]   rel;
			field_kind_t  kind;
			int unsigned  slot;
			int unsigned  offs;
			logic [15:0]  chk;
			logic         chk_ok;
			logic [15:0]  calc;
			have = 1'b0;
			rel = 8'h00;
			kind = KIND_CALL;
			slot = 0;
			offs = 0;
			if (length_seen < MIN_FRAME_LEN) begin
				length_seen++;
			end

			// classify the byte leaving the two-byte delay
			if (fill >= 2) begin
				rel = held[0];
				crc = x25_update(crc, rel);
				case (phase)
					PH_ADDRESS: begin
						slot = addr_count;
						have = 1'b1;
						if (addr_pos < CALL_LEN) begin
							kind = KIND_CALL;
							offs = addr_pos;
							addr_pos++;
						end else begin
							kind = KIND_SSID;
							addr_pos = 0;
							addr_count++;
							if (rel[0] || addr_count >= MAX_ADDRESSES) begin
								phase = PH_CONTROL;
							end
						end
					end
					PH_CONTROL: begin
						kind = KIND_CTRL;
						have = 1'b1;
						phase = (rel[1:0] == CTRL_PID_CODE) ? PH_PID : PH_INFO;
					end
					PH_PID: begin
						kind = KIND_PID;
						have = 1'b1;
						phase = PH_INFO;
					end
					default: begin
						if (info_count < MAX_INFO_BYTES) begin
							kind = KIND_INFO;
							offs = info_count & 8'hFF;
							info_count++;
							have = 1'b1;
						end else begin
							truncated = 1'b1;
						end
					end
				endcase
				held[0] = held[1];
				held[1] = b;
				chk = {b, held[0]};
				chk_ok = 1'b1;
			end else if (fill == 1) begin
				held[1] = b;
				fill = 2;
				chk = {b, held[0]};
				chk_ok = 1'b1;
			end else begin
				held[0] = b;
				fill = 1;
				chk = {8'h00, b};
				chk_ok = 1'b0;
			end

			if (!have && !last) begin
				return;
			end
			r = '0;
			r.present = 1'b1;
			if (have) begin
				r.byte_valid = 1'b1;
				r.field_byte = rel;
				r.field_kind = kind;
				r.address_slot = 4'(slot);
				r.field_offset = 8'(offs);
			end

			// close the frame: status, counts and check value
			if (last) begin
				calc = crc ^ CRC_XOR;
				r.frame_done = 1'b1;
				if (length_seen < MIN_FRAME_LEN) begin
					r.status = ST_SHORT;
				end else if (phase == PH_ADDRESS || phase == PH_CONTROL) begin
					r.status = ST_NO_CTRL;
				end else if (phase == PH_PID) begin
					r.status = ST_NO_PID;
				end else begin
					r.status = ST_OK;
				end
				r.address_total = 4'(addr_count);
				r.info_total = 9'(info_count);
				r.info_truncated = truncated;
				r.received_check = chk;
				r.check_ok = chk_ok && (calc == chk);
				clear_frame();
			end
			awaited_reports.push_back(r);
		endfunction

		function void compare_field(string name, int unsigned want, int unsigned got);
			if (want != got) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("mismatch in %s: expected %0h, got %0h", name, want, got);
				end
			end
		endfunction

		// Match one output transaction against the oldest queued report
		function void match_result(pff_result_t got);
			pff_result_t want;
			if (awaited_reports.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("unexpected result: field_byte %0h frame_done %0b",
						got.field_byte, got.frame_done);
				end
				return;
			end
			want = awaited_reports.pop_front();
			compare_field("byte_valid", want.byte_valid, got.byte_valid);
			compare_field("field_byte", want.field_byte, got.field_byte);
			compare_field("field_kind", want.field_kind, got.field_kind);
			compare_field("address_slot", want.address_slot, got.address_slot);
			compare_field("field_offset", want.field_offset, got.field_offset);
			compare_field("frame_done", want.frame_done, got.frame_done);
			compare_field("status", want.status, got.status);
			compare_field("address_total", want.address_total, got.address_total);
			compare_field("info_total", want.info_total, got.info_total);
			compare_field("info_truncated", want.info_truncated, got.info_truncated);
			compare_field("received_check", want.received_check, got.received_check);
			compare_field("check_ok", want.check_ok, got.check_ok);
		endfunction
	endclass

	logic clk;
	logic arst_n;

	pff_in_if  frame_in();
	pff_out_if field_out();

	packet_frame_field_parser_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.frame_in (frame_in),
		.field_out(field_out)
	);

	field_report_board board = new();

	logic [7:0] frame_bytes[$];
	int         bytes_sent = 0;
	int         burst_left = 0;
	bit         hold_request = 1'b0;

	// Clock
	initial begin
		clk = 1'b0;
		forever begin
			#10 clk = ~clk;
		end
	end

	// Watch both channels at the rising edge
	always @(posedge clk) begin
		pff_result_t got;
		if (arst_n) begin
			if (frame_in.valid && frame_in.ready) begin
				board.predict_byte(frame_in.data_byte, frame_in.frame_end);
			end
			if (field_out.valid && field_out.ready) begin
				got = '0;
				got.present = 1'b1;
				got.byte_valid = field_out.byte_valid;
				got.field_byte = field_out.field_byte;
				got.field_kind = field_kind_t'(field_out.field_kind);
				got.address_slot = field_out.address_slot;
				got.field_offset = field_out.field_offset;
				got.frame_done = field_out.frame_done;
				got.status = status_t'(field_out.status);
				got.address_total = field_out.address_total;
				got.info_total = field_out.info_total;
				got.info_truncated = field_out.info_truncated;
				got.received_check = field_out.received_check;
				got.check_ok = field_out.check_ok;
				board.match_result(got);
			end
		end
	end

	// Receiver: stall on shifting patterns, or hold off for a long stretch on request
	initial begin
		rx_mode_t mode;
		int       left;
		mode = RX_OPEN;
		left = 0;
		field_out.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				field_out.ready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				if (left == 0) begin
					mode = rx_mode_t'($urandom_range(0, 3));
					left = $urandom_range(20, 120);
				end
				left--;
				case (mode)
					RX_OPEN:   field_out.ready <= 1'b1;
					RX_COIN:   field_out.ready <= 1'($urandom_range(0, 1));
					RX_MOSTLY: field_out.ready <= ($urandom_range(0, 7) != 0);
					default:   field_out.ready <= ($urandom_range(0, 7) == 0);
				endcase
			end
		end
	end

	// Offer one byte; insert a random gap between bursts
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				frame_in.valid <= 1'b0;
			end
		end
		burst_left--;
		@(negedge clk);
		frame_in.valid <= 1'b1;
		frame_in.data_byte <= b;
		frame_in.frame_end <= last;
		do begin
			@(posedge clk);
		end while (!frame_in.ready);
		bytes_sent++;
	endtask

	task automatic send_frame();
		for (int i = 0; i < frame_bytes.size(); i++) begin
			send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
		end
	endtask

	// Drop valid and wait until every queued report has come out
	task automatic pause_until_drained();
		@(negedge clk);
		frame_in.valid <= 1'b0;
		burst_left = 0;
		while (board.awaited_reports.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// Address field, control, optional PID and information, no check sequence
	task automatic build_body(input int n_addr, input bit mark_end, input logic [7:0] ctrl,
		input int n_info);
		logic [7:0] ssid;
		frame_bytes.delete();
		for (int a = 0; a < n_addr; a++) begin
			repeat (CALL_LEN) begin
				if ($urandom_range(0, 3) == 0) begin
					frame_bytes.push_back(8'($urandom));
				end else begin
					frame_bytes.push_back({7'($urandom_range(65, 90)), 1'b0});
				end
			end
			ssid = 8'($urandom);
			ssid[0] = (a == n_addr - 1) && mark_end;
			frame_bytes.push_back(ssid);
		end
		frame_bytes.push_back(ctrl);
		if (ctrl[1:0] == CTRL_PID_CODE) begin
			frame_bytes.push_back(($urandom_range(0, 1) == 0) ? 8'hF0 : 8'($urandom));
		end
		repeat (n_info) frame_bytes.push_back(8'($urandom));
	endtask

	// Append the check sequence, low byte first; corrupt one bit when asked
	task automatic close_frame(input bit good);
		logic [15:0] acc;
		acc = CRC_INIT;
		foreach (frame_bytes[i]) begin
			acc = field_report_board::x25_update(acc, frame_bytes[i]);
		end
		acc = acc ^ CRC_XOR;
		if (!good) begin
			acc = acc ^ (16'h0001 << $urandom_range(0, 15));
		end
		frame_bytes.push_back(acc[7:0]);
		frame_bytes.push_back(acc[15:8]);
	endtask

	task automatic send_random_frame(input int idx);
		int         pick;
		int         n_addr;
		int         n_info;
		int         cut;
		bit         mark_end;
		bit         good;
		logic [7:0] ctrl;
		pick = $urandom_range(0, 99);
		n_addr = ($urandom_range(0, 4) == 0) ? $urandom_range(5, MAX_ADDRESSES) : $urandom_range(2, 4);
		ctrl = 8'($urandom);
		if ($urandom_range(0, 2) == 0) begin
			ctrl[1:0] = CTRL_PID_CODE;
		end
		n_info = ($urandom_range(0, 39) == 0) ? $urandom_range(250, 270) : $urandom_range(0, 24);
		good = ($urandom_range(0, 9) != 0);
		mark_end = 1'b1;

		// force one overflowing frame and one address-limit frame early on
		if (idx == 3) begin
			pick = 0;
			n_info = MAX_INFO_BYTES + 6;
		end
		if (idx == 5) begin
			pick = 70;
		end

		if (pick < 78) begin
			if (pick >= 70) begin
				n_addr = MAX_ADDRESSES;
				mark_end = $urandom_range(0, 1);
			end
			build_body(n_addr, mark_end, ctrl, n_info);
			close_frame(good);
		end else if (pick < 88) begin
			// cut the body short: anywhere, right after control, or inside the address field
			build_body(n_addr, mark_end, ctrl, n_info);
			case ($urandom_range(0, 2))
				0:       cut = $urandom_range(0, frame_bytes.size());
				1:       cut = 7 * n_addr + 1;
				default: cut = $urandom_range(0, 7 * n_addr);
			endcase
			while (frame_bytes.size() > cut) begin
				void'(frame_bytes.pop_back());
			end
			close_frame(good);
		end else begin
			frame_bytes.delete();
			repeat ($urandom_range(1, 20)) frame_bytes.push_back(8'($urandom));
		end
		send_frame();
	endtask

	// Stimulus
	initial begin
		int frame_no;
		arst_n = 1'b0;
		frame_in.valid = 1'b0;
		frame_in.data_byte = 8'h00;
		frame_in.frame_end = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// one-byte frame
		frame_bytes = '{8'hFF};
		send_frame();
		// two-byte frame: the check covers no bytes
		frame_bytes = '{8'h00, 8'h00};
		send_frame();
		// well-formed UI frame with extreme byte values
		frame_bytes = '{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
			8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'h61,
			8'h03, 8'hF0, 8'hFF, 8'h00};
		close_frame(1'b1);
		send_frame();
		pause_until_drained();

		frame_no = 0;
		while (bytes_sent < BYTE_GOAL) begin
			if (frame_no == 10) begin
				hold_request = 1'b1;
			end
			if (frame_no == 20) begin
				pause_until_drained();
			end
			send_random_frame(frame_no);
			frame_no++;
		end

		pause_until_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.mismatches == 0 && board.awaited_reports.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

	// Timeout
	initial begin
		#5000000;
		$display("testbench: done, errors");
		$finish;
	end

endmodule
